>>> rtl/tile_gid_to_texture_and_world_coords_core_macros.svh
// ----------------------------------------------------------------------------
// Tile ID translator assertion macros
// Shared concurrent assertion forms. Each one is clocked on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TILE_GID_TO_TEXTURE_AND_WORLD_COORDS_CORE_MACROS_SVH
`define TILE_GID_TO_TEXTURE_AND_WORLD_COORDS_CORE_MACROS_SVH

// Same-cycle implication.
`define TGTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TGTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tgtc_pkg.sv
// ----------------------------------------------------------------------------
// Tile ID translator package
// Widths, codes, reset values and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tgtc_pkg;

    localparam int NUM_TILESETS_DEF = 4;
    localparam int MAX_ROWS_DEF     = 1024;

    localparam int TW_W       = 9;
    localparam int LW_W       = 11;
    localparam int CNT_W      = 3;
    localparam int SLOT_W     = 2;
    localparam int ID_W       = 16;
    localparam int TEX_W      = 13;
    localparam int TEXY_W     = 24;
    localparam int WORLD_W    = 18;
    localparam int STATUS_W   = 3;
    localparam int CELL_W     = 20;
    localparam int DVD_W      = 20;
    localparam int DVS_W      = 13;
    localparam int STEP_W     = 5;
    localparam int MUL_A_W    = 16;
    localparam int PROD_W     = MUL_A_W + TW_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = STATUS_W;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PLACED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSET  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NARROW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ROWOVF = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LOADED = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILESET_COUNT = 2'd3;

    localparam logic [TW_W-1:0]  TILE_WIDTH_RST    = 9'd16;
    localparam logic [TW_W-1:0]  TILE_HEIGHT_RST   = 9'd16;
    localparam logic [LW_W-1:0]  LAYER_WIDTH_RST   = 11'd32;
    localparam logic [CNT_W-1:0] TILESET_COUNT_RST = 3'd0;

    // Divider operand selects and their step counts.
    localparam logic [1:0] DIV_CELL  = 2'd0;
    localparam logic [1:0] DIV_TPR   = 2'd1;
    localparam logic [1:0] DIV_LOCAL = 2'd2;

    localparam logic [STEP_W-1:0] STEPS_CELL  = 5'd20;
    localparam logic [STEP_W-1:0] STEPS_TPR   = 5'd13;
    localparam logic [STEP_W-1:0] STEPS_LOCAL = 5'd16;

    // Multiplier operand selects.
    localparam logic [1:0] MUL_TEX_X   = 2'd0;
    localparam logic [1:0] MUL_TEX_Y   = 2'd1;
    localparam logic [1:0] MUL_WORLD_X = 2'd2;
    localparam logic [1:0] MUL_WORLD_Y = 2'd3;

    typedef struct packed {
        logic                take;
        logic                div_start;
        logic [1:0]          div_sel;
        logic                cap_cell;
        logic                look;
        logic                cap_tpr;
        logic                cap_tex;
        logic                mul_en;
        logic [1:0]          mul_sel;
        logic                finish;
        logic [STATUS_W-1:0] status;
    } tgtc_cmd_t;

    typedef struct packed {
        logic is_load;
        logic id_zero;
        logic div_done;
        logic row_ovf;
        logic hit;
        logic tw_zero;
        logic tpr_zero;
    } tgtc_stat_t;

endpackage

`default_nettype wire

>>> rtl/tgtc_div.sv
// ----------------------------------------------------------------------------
// Tile ID translator divider
// Restoring divider, one quotient bit per cycle. The dividend arrives left
// aligned so that only the significant bits are iterated.
// ----------------------------------------------------------------------------
`default_nettype none

module tgtc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tgtc_pkg::STEP_W-1:0] steps,
    input  wire logic [tgtc_pkg::DVD_W-1:0]  dividend,
    input  wire logic [tgtc_pkg::DVS_W-1:0]  divisor,
    output logic                            busy,
    output logic                            done,
    output logic [tgtc_pkg::DVD_W-1:0]       quotient,
    output logic [tgtc_pkg::DVS_W-1:0]       remainder
);
    import tgtc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // The remainder stays below the divisor, so the trial value fits one
    // bit more than the divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/tgtc_ctrl.sv
// ----------------------------------------------------------------------------
// Tile ID translator controller
// Sequences one item at a time through the checks, the three divisions and
// the four multiplications, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tile_gid_to_texture_and_world_coords_core_macros.svh"

module tgtc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire tgtc_pkg::tgtc_stat_t  stat,
    output tgtc_pkg::tgtc_cmd_t        cmd
);
    import tgtc_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_DIV_CELL = 4'd2;
    localparam logic [3:0] S_ROW      = 4'd3;
    localparam logic [3:0] S_SET      = 4'd4;
    localparam logic [3:0] S_DIV_TPR  = 4'd5;
    localparam logic [3:0] S_TPR      = 4'd6;
    localparam logic [3:0] S_DIV_LOC  = 4'd7;
    localparam logic [3:0] S_MUL_TX   = 4'd8;
    localparam logic [3:0] S_MUL_TY   = 4'd9;
    localparam logic [3:0] S_MUL_WX   = 4'd10;
    localparam logic [3:0] S_MUL_WY   = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.status     = status_reg;
        in_ready       = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_load)
                begin
                    status_next = ST_LOADED;
                    state_next  = S_DONE;
                end
                else if (stat.id_zero)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CELL;
                    state_next    = S_DIV_CELL;
                end
            end
            S_DIV_CELL:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_cell = 1'b1;
                    state_next   = S_ROW;
                end
            end
            S_ROW:
            begin
                if (stat.row_ovf)
                begin
                    status_next = ST_ROWOVF;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.look   = 1'b1;
                    state_next = S_SET;
                end
            end
            S_SET:
            begin
                if (!stat.hit)
                begin
                    status_next = ST_NOSET;
                    state_next  = S_DONE;
                end
                else if (stat.tw_zero)
                begin
                    status_next = ST_NARROW;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_TPR;
                    state_next    = S_DIV_TPR;
                end
            end
            S_DIV_TPR:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_tpr = 1'b1;
                    state_next  = S_TPR;
                end
            end
            S_TPR:
            begin
                if (stat.tpr_zero)
                begin
                    status_next = ST_NARROW;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_LOCAL;
                    state_next    = S_DIV_LOC;
                end
            end
            S_DIV_LOC:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_tex = 1'b1;
                    state_next  = S_MUL_TX;
                end
            end
            S_MUL_TX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TEX_X;
                state_next  = S_MUL_TY;
            end
            S_MUL_TY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TEX_Y;
                state_next  = S_MUL_WX;
            end
            S_MUL_WX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WORLD_X;
                state_next  = S_MUL_WY;
            end
            S_MUL_WY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WORLD_Y;
                status_next = ST_PLACED;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // The result register frees up in the same cycle it is taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_PLACED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `TGTC_ASSERT_IMP(a_done_in_div_state, stat.div_done, (state_reg == S_DIV_CELL) || (state_reg == S_DIV_TPR) || (state_reg == S_DIV_LOC), "divider finished outside a divide state")
    `TGTC_ASSERT_NXT(a_finish_sets_valid, cmd.finish, out_valid_reg && (state_reg == S_IDLE), "finished item did not raise output valid")

endmodule

`default_nettype wire

>>> rtl/tgtc_dp.sv
// ----------------------------------------------------------------------------
// Tile ID translator datapath
// Configuration registers, tileset table, cell counter, range search, the
// shared divider and multiplier, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tile_gid_to_texture_and_world_coords_core_macros.svh"

module tgtc_dp #(
    parameter int NUM_TILESETS = tgtc_pkg::NUM_TILESETS_DEF,
    parameter int MAX_ROWS     = tgtc_pkg::MAX_ROWS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [tgtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tgtc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [tgtc_pkg::IN_DATA_W-1:0]   in_data,
    input  wire logic [tgtc_pkg::IN_USER_W-1:0]   in_user,
    output logic [tgtc_pkg::OUT_DATA_W-1:0]       out_data,
    output logic [tgtc_pkg::OUT_USER_W-1:0]       out_user,
    input  wire tgtc_pkg::tgtc_cmd_t              cmd,
    output tgtc_pkg::tgtc_stat_t                  stat
);
    import tgtc_pkg::*;

    localparam int SET_W = (NUM_TILESETS > 1) ? $clog2(NUM_TILESETS) : 1;

    // Input item fields.
    logic              command_in;
    logic              lstart_in;
    logic [SLOT_W-1:0] slot_in;
    logic [ID_W-1:0]   fid_in;
    logic [TEX_W-1:0]  texw_in;
    logic [ID_W-1:0]   id_in;

    assign command_in = in_user[0];
    assign lstart_in  = in_user[1];
    assign slot_in    = in_data[1:0];
    assign fid_in     = in_data[17:2];
    assign texw_in    = in_data[30:18];
    assign id_in      = in_data[46:31];

    logic [TW_W-1:0]   tile_width_reg;
    logic [TW_W-1:0]   tile_height_reg;
    logic [LW_W-1:0]   layer_width_reg;
    logic [CNT_W-1:0]  tileset_count_reg;
    logic [CELL_W-1:0] cell_reg;

    logic [ID_W-1:0]   fid_tbl_reg  [NUM_TILESETS];
    logic [TEX_W-1:0]  texw_tbl_reg [NUM_TILESETS];

    logic              command_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ID_W-1:0]   id_reg;
    logic [CELL_W-1:0] idx_reg;
    logic [CELL_W-1:0] row_reg;
    logic [LW_W-1:0]   col_reg;
    logic              hit_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TEX_W-1:0]  tpr_reg;
    logic [TEX_W-1:0]  tcol_reg;
    logic [ID_W-1:0]   trow_reg;
    logic [TEX_W-1:0]  tx_reg;
    logic [TEXY_W-1:0] ty_reg;
    logic [WORLD_W-1:0] wx_reg;
    logic [WORLD_W-1:0] wy_reg;

    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_set_reg;
    logic [TEX_W-1:0]    out_tx_reg;
    logic [TEXY_W-1:0]   out_ty_reg;
    logic [WORLD_W-1:0]  out_wx_reg;
    logic [WORLD_W-1:0]  out_wy_reg;

    logic [CELL_W-1:0] start_idx;
    logic [LW_W-1:0]   lw_eff;
    logic [ID_W-1:0]   fid_sel;
    logic [TEX_W-1:0]  texw_sel;
    logic [ID_W-1:0]   local_id;

    logic [NUM_TILESETS-1:0] match;
    logic                    hit_c;
    logic [SET_W-1:0]        set_c;

    logic              div_busy;
    logic              div_done;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [STEP_W-1:0] div_steps;
    logic [DVD_W-1:0]  div_quo;
    logic [DVS_W-1:0]  div_rem;

    logic [MUL_A_W-1:0] mul_a;
    logic [TW_W-1:0]    mul_b;
    logic [PROD_W-1:0]  prod;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg    <= TILE_WIDTH_RST;
            tile_height_reg   <= TILE_HEIGHT_RST;
            layer_width_reg   <= LAYER_WIDTH_RST;
            tileset_count_reg <= TILESET_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TILE_WIDTH:    tile_width_reg    <= cfg_data[TW_W-1:0];
                REG_TILE_HEIGHT:   tile_height_reg   <= cfg_data[TW_W-1:0];
                REG_LAYER_WIDTH:   layer_width_reg   <= cfg_data[LW_W-1:0];
                REG_TILESET_COUNT: tileset_count_reg <= cfg_data[CNT_W-1:0];
                default:           tile_width_reg    <= tile_width_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell counter: every translate item takes the next cell.
    // ------------------------------------------------------------------
    assign start_idx = lstart_in ? '0 : cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (cmd.take && command_in)
        begin
            cell_reg <= start_idx + CELL_W'(1);
        end
    end

    // Tileset table; a slot beyond the table writes nothing.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_TILESETS; i++)
        begin
            if (cmd.take && !command_in && (int'(slot_in) == i))
            begin
                fid_tbl_reg[i]  <= fid_in;
                texw_tbl_reg[i] <= texw_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            command_reg <= command_in;
            slot_reg    <= slot_in;
            id_reg      <= id_in;
            idx_reg     <= start_idx;
        end
    end

    // ------------------------------------------------------------------
    // Range search: entry i owns IDs from its first ID up to the next
    // entry's first ID; the last active entry has no upper bound.
    // ------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < NUM_TILESETS; g++)
        begin : g_match
            if (g < NUM_TILESETS - 1)
            begin : g_mid
                assign match[g] = (int'(tileset_count_reg) > g)
                                  && (id_reg >= fid_tbl_reg[g])
                                  && ((int'(tileset_count_reg) <= g + 1)
                                      || (id_reg < fid_tbl_reg[g+1]));
            end
            else
            begin : g_last
                assign match[g] = (int'(tileset_count_reg) > g)
                                  && (id_reg >= fid_tbl_reg[g]);
            end
        end
    endgenerate

    always_comb
    begin
        hit_c = 1'b0;
        set_c = '0;
        for (int i = NUM_TILESETS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_c = 1'b1;
                set_c = SET_W'(i);
            end
        end
    end

    assign fid_sel  = fid_tbl_reg[set_reg];
    assign texw_sel = texw_tbl_reg[set_reg];
    assign local_id = id_reg - fid_sel;
    assign lw_eff   = (layer_width_reg == '0) ? LW_W'(1) : layer_width_reg;

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    always_comb
    begin
        case (cmd.div_sel)
            DIV_TPR:
            begin
                div_dvd   = {texw_sel, {(DVD_W - TEX_W){1'b0}}};
                div_dvs   = DVS_W'(tile_width_reg);
                div_steps = STEPS_TPR;
            end
            DIV_LOCAL:
            begin
                div_dvd   = {local_id, {(DVD_W - ID_W){1'b0}}};
                div_dvs   = tpr_reg;
                div_steps = STEPS_LOCAL;
            end
            default:
            begin
                div_dvd   = idx_reg;
                div_dvs   = DVS_W'(lw_eff);
                div_steps = STEPS_CELL;
            end
        endcase
    end

    tgtc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .steps     (div_steps),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_cell)
        begin
            row_reg <= div_quo;
            col_reg <= div_rem[LW_W-1:0];
        end
        if (cmd.look)
        begin
            hit_reg <= hit_c;
            set_reg <= set_c;
        end
        if (cmd.cap_tpr)
        begin
            tpr_reg <= div_quo[TEX_W-1:0];
        end
        if (cmd.cap_tex)
        begin
            trow_reg <= div_quo[ID_W-1:0];
            tcol_reg <= div_rem;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier, one product per cycle. The row is below MAX_ROWS
    // here, so its low bits carry the whole value.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_TEX_X:
            begin
                mul_a = MUL_A_W'(tcol_reg);
                mul_b = tile_width_reg;
            end
            MUL_TEX_Y:
            begin
                mul_a = trow_reg;
                mul_b = tile_height_reg;
            end
            MUL_WORLD_X:
            begin
                mul_a = MUL_A_W'(col_reg);
                mul_b = tile_width_reg;
            end
            default:
            begin
                mul_a = row_reg[MUL_A_W-1:0];
                mul_b = tile_height_reg;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_TEX_X:   tx_reg <= prod[TEX_W-1:0];
                MUL_TEX_Y:   ty_reg <= prod[TEXY_W-1:0];
                MUL_WORLD_X: wx_reg <= prod[WORLD_W-1:0];
                default:     wy_reg <= prod[WORLD_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= cmd.status;
            if ((cmd.status == ST_PLACED) || (cmd.status == ST_NARROW))
            begin
                out_set_reg <= SLOT_W'(set_reg);
            end
            else if (cmd.status == ST_LOADED)
            begin
                out_set_reg <= slot_reg;
            end
            else
            begin
                out_set_reg <= '0;
            end
            if (cmd.status == ST_PLACED)
            begin
                out_tx_reg <= tx_reg;
                out_ty_reg <= ty_reg;
                out_wx_reg <= wx_reg;
                out_wy_reg <= wy_reg;
            end
            else
            begin
                out_tx_reg <= '0;
                out_ty_reg <= '0;
                out_wx_reg <= '0;
                out_wy_reg <= '0;
            end
        end
    end

    assign out_data = {{(OUT_DATA_W - SLOT_W - TEX_W - TEXY_W - 2 * WORLD_W){1'b0}},
                       out_wy_reg, out_wx_reg, out_ty_reg, out_tx_reg, out_set_reg};
    assign out_user = out_status_reg;

    assign stat.is_load  = !command_reg;
    assign stat.id_zero  = (id_reg == '0);
    assign stat.div_done = div_done;
    assign stat.row_ovf  = (int'(row_reg) >= MAX_ROWS);
    assign stat.hit      = hit_reg;
    assign stat.tw_zero  = (tile_width_reg == '0);
    assign stat.tpr_zero = (tpr_reg == '0);

    `TGTC_ASSERT_IMP(a_div_start_idle, cmd.div_start, !div_busy, "divider started while busy")
    `TGTC_ASSERT_IMP(a_mul_after_tpr, cmd.mul_en, hit_reg && (tpr_reg != '0), "multiply without a matching tileset")
    `TGTC_ASSERT_IMP(a_look_row_in_range, cmd.look, int'(row_reg) < MAX_ROWS, "search started on an overflowed row")

endmodule

`default_nettype wire

>>> rtl/tile_gid_to_texture_and_world_coords_core.sv
// ----------------------------------------------------------------------------
// Tile ID translator
// Turns a stream of tile global IDs into texture rectangle origins and world
// positions, and loads the tileset table.
//
//   channel   direction  handshake                       payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   tdata, tuser
//   m_axis    out        m_axis_tvalid / m_axis_tready   tdata, tuser
//   cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// A load item or an empty cell goes from the check state straight to the done
// state. A placed tile passes through three divisions on the shared
// one-bit-per-cycle divider, 20 steps for the cell index, 13 for tiles per row
// and 16 for the local ID, then through four multiplications to the done state.
// One item is in work at a time; the next is accepted while a result waits.
// Asynchronous reset sets the cell index, configuration and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_gid_to_texture_and_world_coords_core #(
    parameter int NUM_TILESETS = tgtc_pkg::NUM_TILESETS_DEF,
    parameter int MAX_ROWS     = tgtc_pkg::MAX_ROWS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // slot [1:0], first_id [17:2], texture_width [30:18], tile_id [46:31]
    input  wire logic [tgtc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command [0], layer_start [1]
    input  wire logic [tgtc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tileset_index [1:0], tex_x [14:2], tex_y [38:15], world_x [56:39],
    // world_y [74:57]
    output logic [tgtc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status [2:0]
    output logic [tgtc_pkg::OUT_USER_W-1:0]       m_axis_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tgtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tgtc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgtc_pkg::*;

    tgtc_cmd_t  cmd;
    tgtc_stat_t stat;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    tgtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tgtc_dp #(
        .NUM_TILESETS (NUM_TILESETS),
        .MAX_ROWS     (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
